### design/fbfa_pkg.sv
package fbfa_pkg;

	// Pool geometry
	localparam int NUM_BLOCKS = 256;
	localparam int WORD_BYTES = 8;
	localparam int WORD_SHIFT = $clog2(WORD_BYTES);

	// Field widths
	localparam int IDX_W   = $clog2(NUM_BLOCKS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int SIZE_W  = 13;
	localparam int QSZ_W   = SIZE_W - WORD_SHIFT + 1;
	localparam int PROD_W  = IDX_W + QSZ_W;
	localparam int OFF_W   = 21;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SIZE_W;

	// Three pool header words plus the block's own header word
	localparam int LEAD_WORDS = 4;

	// Register reset values
	localparam int RST_BLOCK_COUNT = 256;
	localparam int RST_BLOCK_SIZE  = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = CFG_IDX_W'(1);

	// Request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
	localparam logic [STAT_W-1:0] STAT_EMPTY = STAT_W'(1);
	localparam logic [STAT_W-1:0] STAT_RANGE = STAT_W'(2);

	// Controller to datapath commands
	typedef struct packed {
		logic latch_req;
		logic commit;
	} fbfa_cmd_t;

	// Clamp a written block count to 1..NUM_BLOCKS
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc);
		logic [CNT_W-1:0] n;
		n = bc;
		if (n == '0)
			n = CNT_W'(1);
		if (n > CNT_W'(NUM_BLOCKS))
			n = CNT_W'(NUM_BLOCKS);
		return n;
	endfunction

	// Link of block k right after a rebuild with n blocks
	function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] k,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] k1;
		k1 = {1'b0, k} + CNT_W'(1);
		return (k1 < n) ? k1[IDX_W-1:0] : '0;
	endfunction

	// Size in words plus one pad word and one header word
	function automatic logic [QSZ_W-1:0] stride_words(input logic [SIZE_W-1:0] sz);
		return QSZ_W'(sz >> WORD_SHIFT) + QSZ_W'(2);
	endfunction

endpackage

### design/fbfa_ctrl.sv
module fbfa_ctrl
	import fbfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output fbfa_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic accept;
	logic commit;

	// Take a request only when idle; the result register may still be full
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	// Finish once the result register is empty or draining this cycle
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	assign cmd.latch_req = accept;
	assign cmd.commit    = commit;
	assign rsp_valid     = rsp_valid_q;

	// State and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (commit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

### design/fbfa_dp.sv
module fbfa_dp
	import fbfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [IDX_W-1:0]      block_index,
	input  fbfa_cmd_t             cmd,
	output logic [STAT_W-1:0]     status,
	output logic [IDX_W-1:0]      alloc_index,
	output logic [OFF_W-1:0]      byte_offset,
	output logic [CNT_W-1:0]      free_count
);

	// Configuration-derived state
	logic [CNT_W-1:0]  cnt_q;
	logic [QSZ_W-1:0]  qsz_q;
	// Free list state
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  free_q;
	logic [NUM_BLOCKS-1:0] vld_q;
	logic [IDX_W-1:0]  link_mem [NUM_BLOCKS];
	logic [IDX_W-1:0]  rd_link_q;
	logic              rd_vld_q;
	// Latched request
	logic              type_q;
	logic [IDX_W-1:0]  idx_q;
	// Result payload
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  aidx_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  fcnt_q;

	logic              cfg_hit;
	logic [CNT_W-1:0]  cnt_new;
	logic [IDX_W-1:0]  head_link;
	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   words;
	logic [OFF_W-1:0]  off_next;
	logic              do_alloc;
	logic              do_free;
	logic [STAT_W-1:0] stat_next;
	logic [CNT_W-1:0]  free_next;

	assign cfg_hit = cfg_we && (cfg_index == CFG_BLOCK_COUNT || cfg_index == CFG_BLOCK_SIZE);
	assign cnt_new = (cfg_we && cfg_index == CFG_BLOCK_COUNT) ?
		eff_count(cfg_data[CNT_W-1:0]) : cnt_q;

	// Link of the head: an unwritten entry still holds its rebuild value
	assign head_link = rd_vld_q ? rd_link_q : reset_link(head_q, cnt_q);

	// Data offset of the head block
	assign prod     = PROD_W'(head_q) * PROD_W'(qsz_q);
	assign words    = {1'b0, prod} + (PROD_W+1)'(LEAD_WORDS);
	assign off_next = OFF_W'({words, {WORD_SHIFT{1'b0}}});

	// Request decode
	always_comb begin
		do_alloc  = 1'b0;
		do_free   = 1'b0;
		stat_next = STAT_OK;
		free_next = free_q;
		if (type_q == REQ_ALLOC) begin
			if (free_q == '0) begin
				stat_next = STAT_EMPTY;
			end else begin
				do_alloc  = 1'b1;
				free_next = free_q - CNT_W'(1);
			end
		end else begin
			if ({1'b0, idx_q} >= cnt_q) begin
				stat_next = STAT_RANGE;
			end else begin
				do_free = 1'b1;
				if (free_q < cnt_q)
					free_next = free_q + CNT_W'(1);
			end
		end
	end

	// Control state: configuration, list head, counter, link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_W'(RST_BLOCK_COUNT);
			qsz_q  <= stride_words(SIZE_W'(RST_BLOCK_SIZE));
			head_q <= '0;
			free_q <= CNT_W'(RST_BLOCK_COUNT);
			vld_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[head_q];
			if (cfg_hit) begin
				cnt_q  <= cnt_new;
				if (cfg_index == CFG_BLOCK_SIZE)
					qsz_q <= stride_words(cfg_data);
				head_q <= '0;
				free_q <= cnt_new;
				vld_q  <= '0;
			end else if (cmd.commit) begin
				free_q <= free_next;
				if (do_alloc) begin
					head_q <= head_link;
				end else if (do_free) begin
					head_q        <= idx_q;
					vld_q[idx_q]  <= 1'b1;
				end
			end
		end
	end

	// Link memory: one write, one registered read at the head
	always_ff @(posedge clk) begin
		if (cmd.commit && do_free)
			link_mem[idx_q] <= head_q;
		rd_link_q <= link_mem[head_q];
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			type_q <= req_type;
			idx_q  <= block_index;
		end
		if (cmd.commit) begin
			status_q <= stat_next;
			aidx_q   <= do_alloc ? head_q : '0;
			off_q    <= do_alloc ? off_next : '0;
			fcnt_q   <= free_next;
		end
	end

	assign status      = status_q;
	assign alloc_index = aidx_q;
	assign byte_offset = off_q;
	assign free_count  = fcnt_q;

endmodule

### design/fixed_block_free_list_allocator_top.sv
// Channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// request  | req_valid / req_stall | req_type, block_index
// result   | rsp_valid / rsp_stall | status, alloc_index, byte_offset, free_count
// config   | cfg_we                | cfg_index, cfg_data
//
// Each request is taken in the idle state, where the head's next link is read from
// the link memory; the working state then updates the list and loads the result.
// A new request is taken in the cycle after a result is loaded, even while that
// result waits; a stalled result holds the request in the working state.
// Reset and every write to BLOCK_COUNT or BLOCK_SIZE rebuild the free list at once
// through per-block link valid bits; no clearing pass is needed.
module fixed_block_free_list_allocator_top
	import fbfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  req_type,
	input  logic [IDX_W-1:0]      block_index,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [STAT_W-1:0]     status,
	output logic [IDX_W-1:0]      alloc_index,
	output logic [OFF_W-1:0]      byte_offset,
	output logic [CNT_W-1:0]      free_count
);

	fbfa_cmd_t cmd;

	// Sequencer
	fbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Free list, link memory and offset math
	fbfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.block_index (block_index),
		.cmd         (cmd),
		.status      (status),
		.alloc_index (alloc_index),
		.byte_offset (byte_offset),
		.free_count  (free_count)
	);

endmodule

### design/fbfa_chk.sv
module fbfa_chk
	import fbfa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  req_type,
	input logic [IDX_W-1:0]      block_index,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input logic [STAT_W-1:0]     status,
	input logic [IDX_W-1:0]      alloc_index,
	input logic [OFF_W-1:0]      byte_offset,
	input logic [CNT_W-1:0]      free_count
);

	// A held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(alloc_index)
			&& $stable(byte_offset) && $stable(free_count))
		else $error("result changed while stalled");

	// Only defined status codes reach the port
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_RANGE))
		else $error("undefined status code");

	// A failed request carries no block
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> alloc_index == '0 && byte_offset == '0)
		else $error("failed request reports a block");

	// A request transfer is followed by a busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken in the working cycle");

	// Free count never exceeds the pool
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> free_count <= CNT_W'(NUM_BLOCKS))
		else $error("free count beyond pool size");

endmodule

bind fixed_block_free_list_allocator_top fbfa_chk u_chk (.*);
